@@ src/tcpn_pkg.sv @@
// ----------------------------------------------------------------------------
// tcpn_pkg: shared definitions for the per-node triangle counter
// Field widths, action codes, reset values and the control/status bundles
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tcpn_pkg;

  // Field widths of the item and result channels
  localparam int ACT_W  = 2;
  localparam int NODE_W = 6;
  localparam int CNT_W  = 14;
  localparam int TOT_W  = 19;
  // Node counts run up to 64 inclusive
  localparam int NCNT_W = 7;

  // Default matrix size and node_count reset value
  localparam int              MAX_NODES_DEF  = 64;
  localparam logic [NCNT_W-1:0] NODE_COUNT_RST = 7'd64;

  // Action codes of an input item
  localparam logic [ACT_W-1:0] ACT_WRITE   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_CLEAR   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_COMPUTE = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic              capture;    // latch entry fields of the input item
    logic              clear_rows; // drop every matrix row
    logic              rd_en;      // read one matrix row
    logic              rd_entry;   // read address from the latched entry row
    logic [NCNT_W-1:0] rd_node;    // read address otherwise
    logic              wr_back;    // merge latched entry into row and write
    logic              load_row;   // take row i as the neighbor set
    logic              clear_cnt;  // zero all node counters and the total
    logic              load_m;     // form common-neighbor mask for row k
    logic              pop;        // partial popcounts of the mask
    logic              acc;        // add mask into counters and total
    logic              emit;       // load one result and shift counters
    logic [NCNT_W-1:0] node_i;
    logic [NCNT_W-1:0] node_k;
    logic [NCNT_W-1:0] emit_idx;
    logic [NCNT_W-1:0] n_act;      // active node count, already clamped
  } tcpn_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free; // result register can take a new result this cycle
  } tcpn_sts_t;

endpackage

`default_nettype wire

@@ src/tcpn_in_if.sv @@
// ----------------------------------------------------------------------------
// tcpn_in_if: input item channel
// Valid/ready channel carrying one matrix load or compute request.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcpn_in_if;
  logic                        valid;
  logic                        ready;
  logic [tcpn_pkg::ACT_W-1:0]  action;
  logic [tcpn_pkg::NODE_W-1:0] row_index;
  logic [tcpn_pkg::NODE_W-1:0] col_index;
  logic                        edge_bit;

  modport source (output valid, output action, output row_index, output col_index,
                  output edge_bit, input ready);
  modport sink   (input valid, input action, input row_index, input col_index,
                  input edge_bit, output ready);
endinterface

`default_nettype wire

@@ src/tcpn_out_if.sv @@
// ----------------------------------------------------------------------------
// tcpn_out_if: result channel
// Valid/ready channel carrying one per-node count result.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcpn_out_if;
  logic                        valid;
  logic                        ready;
  logic [tcpn_pkg::NODE_W-1:0] node_id;
  logic [tcpn_pkg::CNT_W-1:0]  node_triangles;
  logic [tcpn_pkg::TOT_W-1:0]  total_found;
  logic                        last_node;

  modport source (output valid, output node_id, output node_triangles,
                  output total_found, output last_node, input ready);
  modport sink   (input valid, input node_id, input node_triangles,
                  input total_found, input last_node, output ready);
endinterface

`default_nettype wire

@@ src/triangle_count_per_node_top.sv @@
// ----------------------------------------------------------------------------
// triangle_count_per_node_top: per-node triangle counter
// Keeps an adjacency bit matrix, counts per-node triangle incidences on a
// compute request and streams one result per active node.
// ----------------------------------------------------------------------------
// Items are handled one at a time through a row memory with one write port and
// one read port. An entry write steps through accept, row read and write-back;
// a matrix clear and an unused action finish at accept. A compute with n
// active nodes reads and loads each row i, then runs a four-step
// read/mask/popcount/accumulate sequence per neighbor row, followed by n
// results (one per cycle while the result channel is ready). The last result
// may still wait in the result register while the next item is accepted.
// node_count is to be written only while the block is idle; the block does
// not enforce this. 0 counts as 1 and values above MAX_NODES count as MAX_NODES.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_count_per_node_top #(
  parameter int MAX_NODES = tcpn_pkg::MAX_NODES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [tcpn_pkg::NCNT_W-1:0] cfg_wdata,
  tcpn_in_if.sink                          in_ch,
  tcpn_out_if.source                       out_ch
);

  tcpn_pkg::tcpn_cmd_t cmd;
  tcpn_pkg::tcpn_sts_t sts;

  // sequencer
  tcpn_ctrl #(
    .MAX_NODES (MAX_NODES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // matrix, counters and result register
  tcpn_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .sts                (sts),
    .row_index          (in_ch.row_index),
    .col_index          (in_ch.col_index),
    .edge_bit           (in_ch.edge_bit),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_node_id        (out_ch.node_id),
    .out_node_triangles (out_ch.node_triangles),
    .out_total_found    (out_ch.total_found),
    .out_last_node      (out_ch.last_node)
  );

endmodule

`default_nettype wire

@@ src/tcpn_ram.sv @@
// ----------------------------------------------------------------------------
// tcpn_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpn_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ src/tcpn_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcpn_ctrl: sequencer for the per-node triangle counter
// Holds node_count, takes input items and steps the row walk, the
// neighbor-row walk and the result emission through the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpn_ctrl #(
  parameter int MAX_NODES = tcpn_pkg::MAX_NODES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [tcpn_pkg::NCNT_W-1:0] cfg_wdata,
  input  wire logic                        in_valid,
  input  wire logic [tcpn_pkg::ACT_W-1:0]  in_action,
  output      logic                        in_ready,
  output      tcpn_pkg::tcpn_cmd_t         cmd,
  input  wire tcpn_pkg::tcpn_sts_t         sts
);

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_WR_RD  = 9'b000000010,
    ST_WR_WB  = 9'b000000100,
    ST_ROW_RD = 9'b000001000,
    ST_ROW_LD = 9'b000010000,
    ST_K_RD   = 9'b000100000,
    ST_K_M    = 9'b001000000,
    ST_K_POP  = 9'b010000000,
    ST_K_ACC  = 9'b100000000
  } state_t;

  localparam logic [tcpn_pkg::NCNT_W-1:0] MAX_N = tcpn_pkg::NCNT_W'(MAX_NODES);
  localparam logic [tcpn_pkg::NCNT_W-1:0] ONE   = tcpn_pkg::NCNT_W'(1);

  state_t                      state, state_next;
  logic                        emitting, emitting_next;
  logic [tcpn_pkg::NCNT_W-1:0] node_count;
  logic [tcpn_pkg::NCNT_W-1:0] n_act;
  logic [tcpn_pkg::NCNT_W-1:0] i_idx, i_idx_next;
  logic [tcpn_pkg::NCNT_W-1:0] k_idx, k_idx_next;
  logic [tcpn_pkg::NCNT_W-1:0] e_idx, e_idx_next;
  logic                        in_fire;

  // node_count register and its clamp to the usable range
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= tcpn_pkg::NODE_COUNT_RST;
    end else if (cfg_we) begin
      node_count <= cfg_wdata;
    end
  end

  always_comb begin
    if (node_count == '0) begin
      n_act = ONE;
    end else if (node_count > MAX_N) begin
      n_act = MAX_N;
    end else begin
      n_act = node_count;
    end
  end

  // input handshake: items are taken only between operations
  assign in_ready = (state == ST_IDLE) && !emitting;
  assign in_fire  = in_valid && in_ready;

  // next state and loop counters
  always_comb begin
    state_next    = state;
    emitting_next = emitting;
    i_idx_next    = i_idx;
    k_idx_next    = k_idx;
    e_idx_next    = e_idx;
    case (state)
      ST_IDLE: begin
        if (emitting) begin
          if (sts.out_free) begin
            if (e_idx + ONE == n_act) begin
              emitting_next = 1'b0;
            end
            e_idx_next = e_idx + ONE;
          end
        end else if (in_fire) begin
          case (in_action)
            tcpn_pkg::ACT_WRITE: begin
              state_next = ST_WR_RD;
            end
            tcpn_pkg::ACT_COMPUTE: begin
              state_next = ST_ROW_RD;
              i_idx_next = '0;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_WR_RD:  state_next = ST_WR_WB;
      ST_WR_WB:  state_next = ST_IDLE;
      ST_ROW_RD: state_next = ST_ROW_LD;
      ST_ROW_LD: begin
        state_next = ST_K_RD;
        k_idx_next = '0;
      end
      ST_K_RD:   state_next = ST_K_M;
      ST_K_M:    state_next = ST_K_POP;
      ST_K_POP:  state_next = ST_K_ACC;
      ST_K_ACC: begin
        if (k_idx + ONE != n_act) begin
          k_idx_next = k_idx + ONE;
          state_next = ST_K_RD;
        end else if (i_idx + ONE != n_act) begin
          i_idx_next = i_idx + ONE;
          state_next = ST_ROW_RD;
        end else begin
          e_idx_next    = '0;
          emitting_next = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      emitting <= 1'b0;
      i_idx    <= '0;
      k_idx    <= '0;
      e_idx    <= '0;
    end else begin
      state    <= state_next;
      emitting <= emitting_next;
      i_idx    <= i_idx_next;
      k_idx    <= k_idx_next;
      e_idx    <= e_idx_next;
    end
  end

  // command decode
  always_comb begin
    cmd            = '0;
    cmd.capture    = in_fire;
    cmd.clear_rows = in_fire && (in_action == tcpn_pkg::ACT_CLEAR);
    cmd.clear_cnt  = in_fire && (in_action == tcpn_pkg::ACT_COMPUTE);
    cmd.rd_en      = (state == ST_WR_RD) || (state == ST_ROW_RD) || (state == ST_K_RD);
    cmd.rd_entry   = (state == ST_WR_RD);
    cmd.rd_node    = (state == ST_K_RD) ? k_idx : i_idx;
    cmd.wr_back    = (state == ST_WR_WB);
    cmd.load_row   = (state == ST_ROW_LD);
    cmd.load_m     = (state == ST_K_M);
    cmd.pop        = (state == ST_K_POP);
    cmd.acc        = (state == ST_K_ACC);
    cmd.emit       = (state == ST_IDLE) && emitting && sts.out_free;
    cmd.node_i     = i_idx;
    cmd.node_k     = k_idx;
    cmd.emit_idx   = e_idx;
    cmd.n_act      = n_act;
  end

  // walk indices stay inside the active area
  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_K_ACC) |-> (i_idx < n_act) && (k_idx < n_act))
    else $error("tcpn_ctrl: walk index outside active nodes");

  // an entry write takes read and write-back, then returns for the next item
  a_write_seq: assert property (@(posedge clk) disable iff (rst)
    (in_fire && (in_action == tcpn_pkg::ACT_WRITE)) |=> (state == ST_WR_RD) ##1
    (state == ST_WR_WB) ##1 in_ready)
    else $error("tcpn_ctrl: entry write sequence broken");

  // a compute starts the walk at row 0
  a_compute_start: assert property (@(posedge clk) disable iff (rst)
    (in_fire && (in_action == tcpn_pkg::ACT_COMPUTE)) |=>
    (state == ST_ROW_RD) && (i_idx == '0))
    else $error("tcpn_ctrl: compute did not start at row 0");

  // emission never runs past the active node count
  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    emitting |-> (e_idx < n_act))
    else $error("tcpn_ctrl: emit index past active nodes");

endmodule

`default_nettype wire

@@ src/tcpn_dp.sv @@
// ----------------------------------------------------------------------------
// tcpn_dp: datapath of the per-node triangle counter
// Adjacency row memory with per-row valid bits, neighbor mask and popcount
// stages, one counter lane per node, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpn_dp #(
  parameter int MAX_NODES = tcpn_pkg::MAX_NODES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire tcpn_pkg::tcpn_cmd_t         cmd,
  output      tcpn_pkg::tcpn_sts_t         sts,
  input  wire logic [tcpn_pkg::NODE_W-1:0] row_index,
  input  wire logic [tcpn_pkg::NODE_W-1:0] col_index,
  input  wire logic                        edge_bit,
  output      logic                        out_valid,
  input  wire logic                        out_ready,
  output      logic [tcpn_pkg::NODE_W-1:0] out_node_id,
  output      logic [tcpn_pkg::CNT_W-1:0]  out_node_triangles,
  output      logic [tcpn_pkg::TOT_W-1:0]  out_total_found,
  output      logic                        out_last_node
);

  localparam int AW     = $clog2(MAX_NODES);
  localparam int GROUPS = (MAX_NODES + 7) / 8;
  localparam int C_W    = 7;  // pairs per neighbor row, at most 64
  localparam logic [tcpn_pkg::NCNT_W-1:0] MAX_N = tcpn_pkg::NCNT_W'(MAX_NODES);

  // latched entry of a write item
  logic [tcpn_pkg::NODE_W-1:0] wr_row;
  logic [tcpn_pkg::NODE_W-1:0] wr_col;
  logic                        wr_bit;
  logic                        wr_ok;

  // row memory and valid bits
  logic [MAX_NODES-1:0] row_vld;
  logic                 rd_vld;
  logic [MAX_NODES-1:0] ram_q;
  logic [MAX_NODES-1:0] row_q;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        wr_addr;
  logic [MAX_NODES-1:0] wr_mask;
  logic [MAX_NODES-1:0] wr_data;
  logic                 ram_we;

  // walk registers
  logic [MAX_NODES-1:0] keep;
  logic [MAX_NODES-1:0] nb;
  logic [MAX_NODES-1:0] m_bits;
  logic [GROUPS*8-1:0]  m_pad;
  logic [3:0]           grp_cnt [GROUPS];
  logic [C_W-1:0]       pair_cnt;

  // counter lanes
  logic [tcpn_pkg::CNT_W-1:0] cnt [MAX_NODES];
  logic [tcpn_pkg::TOT_W-1:0] total;

  // capture entry fields
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      wr_row <= row_index;
      wr_col <= col_index;
      wr_bit <= edge_bit;
    end
  end

  // entry write: merge one bit into the stored row
  assign wr_ok   = ({1'b0, wr_row} < MAX_N) && ({1'b0, wr_col} < MAX_N);
  assign wr_addr = wr_row[AW-1:0];
  assign wr_mask = MAX_NODES'(1) << wr_col;
  assign wr_data = wr_bit ? (row_q | wr_mask) : (row_q & ~wr_mask);
  assign ram_we  = cmd.wr_back && wr_ok;
  assign rd_addr = cmd.rd_entry ? wr_row[AW-1:0] : cmd.rd_node[AW-1:0];

  tcpn_ram #(
    .WIDTH (MAX_NODES),
    .DEPTH (MAX_NODES)
  ) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // row valid bits: a row never written since reset or clear reads as zero
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_rows) begin
      row_vld <= '0;
    end else if (ram_we) begin
      row_vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_vld <= row_vld[rd_addr];
    end
  end

  assign row_q = rd_vld ? ram_q : '0;

  // active columns
  always_comb begin
    for (int j = 0; j < MAX_NODES; j++) begin
      keep[j] = (tcpn_pkg::NCNT_W'(j) < cmd.n_act);
    end
  end

  // neighbor set of row i, common-neighbor mask of row k, partial popcounts
  assign m_pad = (GROUPS*8)'(m_bits);

  always_ff @(posedge clk) begin
    if (cmd.load_row) begin
      nb <= row_q & keep;
    end
    if (cmd.load_m) begin
      m_bits <= nb[cmd.node_k[AW-1:0]] ? (nb & row_q) : '0;
    end
    if (cmd.pop) begin
      for (int g = 0; g < GROUPS; g++) begin
        grp_cnt[g] <= 4'($countones(m_pad[g*8 +: 8]));
      end
    end
  end

  // pairs found for this neighbor row
  always_comb begin
    pair_cnt = '0;
    for (int g = 0; g < GROUPS; g++) begin
      pair_cnt = pair_cnt + C_W'(grp_cnt[g]);
    end
  end

  // counter lanes: clear, accumulate, or shift toward the result register
  always_ff @(posedge clk) begin
    if (cmd.clear_cnt) begin
      total <= '0;
      for (int j = 0; j < MAX_NODES; j++) begin
        cnt[j] <= '0;
      end
    end else if (cmd.acc) begin
      total <= total + tcpn_pkg::TOT_W'(pair_cnt);
      for (int j = 0; j < MAX_NODES; j++) begin
        cnt[j] <= cnt[j] + tcpn_pkg::CNT_W'(m_bits[j])
                + ((tcpn_pkg::NCNT_W'(j) == cmd.node_i) ? tcpn_pkg::CNT_W'(pair_cnt) : '0)
                + ((tcpn_pkg::NCNT_W'(j) == cmd.node_k) ? tcpn_pkg::CNT_W'(pair_cnt) : '0);
      end
    end else if (cmd.emit) begin
      for (int j = 0; j < MAX_NODES - 1; j++) begin
        cnt[j] <= cnt[j + 1];
      end
      cnt[MAX_NODES-1] <= '0;
    end
  end

  // result register
  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_node_id        <= cmd.emit_idx[tcpn_pkg::NODE_W-1:0];
      out_node_triangles <= cnt[0];
      out_total_found    <= total;
      out_last_node      <= (tcpn_pkg::NCNT_W'(cmd.emit_idx + 1'b1) == cmd.n_act);
    end
  end

  // the final active node carries the last mark
  a_last_mark: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && (tcpn_pkg::NCNT_W'(cmd.emit_idx + 1'b1) == cmd.n_act)) |=> out_last_node)
    else $error("tcpn_dp: last result not marked");

  // a matrix clear leaves no row valid
  a_clear_rows: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_rows |=> (row_vld == '0))
    else $error("tcpn_dp: rows still valid after clear");

  // a result is only loaded into a free result register
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !cmd.emit)
    else $error("tcpn_dp: pending result overwritten");

endmodule

`default_nettype wire
